/* src/bcsc_pkg.sv */
// Shared types and constants for the ball chase speed controller.
// Holds the item structs, the controller/datapath command bundle and all codes.
// No dependencies.
package bcsc_pkg;

	// Input item as it crosses the item channel.
	typedef struct packed {
		logic               busy_req;
		logic               holding_ball;
		logic               target_seen;
		logic signed [15:0] target_angle;
		logic [14:0]        target_distance;
		logic signed [15:0] forward_velocity;
	} bcsc_in_t;

	// Result item as it crosses the result channel.
	typedef struct packed {
		logic [2:0]         command_kind;
		logic signed [15:0] forward_speed;
		logic signed [15:0] turn_rate;
		logic [1:0]         roller_command;
	} bcsc_out_t;

	// Configuration register file contents.
	typedef struct packed {
		logic signed [15:0] focus_gain;
		logic [14:0]        max_turn_rate;
		logic [14:0]        far_speed;
		logic [14:0]        near_speed;
		logic [14:0]        close_distance;
		logic [14:0]        brake_distance_gain;
		logic [14:0]        brake_speed_gain;
		logic [14:0]        min_brake_speed;
	} bcsc_cfg_t;

	// Command kinds.
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_ROLLER = 3'd1;
	localparam logic [2:0] KIND_SEARCH = 3'd2;
	localparam logic [2:0] KIND_STOP   = 3'd3;
	localparam logic [2:0] KIND_DRIVE  = 3'd4;

	// Roller commands.
	localparam logic [1:0] ROLLER_KEEP  = 2'd0;
	localparam logic [1:0] ROLLER_START = 2'd1;
	localparam logic [1:0] ROLLER_STOP  = 2'd2;

	// Multiplier operations of the shared datapath multiplier.
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_OMEGA = 3'd1;
	localparam logic [2:0] OP_T1    = 3'd2;
	localparam logic [2:0] OP_BRAKE = 3'd3;
	localparam logic [2:0] OP_BSPD  = 3'd4;
	localparam logic [2:0] OP_SLOW  = 3'd5;
	localparam logic [2:0] OP_SPEED = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] REG_FOCUS_GAIN          = 3'd0;
	localparam logic [2:0] REG_MAX_TURN_RATE       = 3'd1;
	localparam logic [2:0] REG_FAR_SPEED           = 3'd2;
	localparam logic [2:0] REG_NEAR_SPEED          = 3'd3;
	localparam logic [2:0] REG_CLOSE_DISTANCE      = 3'd4;
	localparam logic [2:0] REG_BRAKE_DISTANCE_GAIN = 3'd5;
	localparam logic [2:0] REG_BRAKE_SPEED_GAIN    = 3'd6;
	localparam logic [2:0] REG_MIN_BRAKE_SPEED     = 3'd7;

	// Configuration reset values.
	localparam logic signed [15:0] FOCUS_GAIN_RST    = 16'sd256;
	localparam logic [14:0] MAX_TURN_RATE_RST        = 15'd768;
	localparam logic [14:0] FAR_SPEED_RST            = 15'd512;
	localparam logic [14:0] NEAR_SPEED_RST           = 15'd128;
	localparam logic [14:0] CLOSE_DISTANCE_RST       = 15'd128;
	localparam logic [14:0] BRAKE_DISTANCE_GAIN_RST  = 15'd256;
	localparam logic [14:0] BRAKE_SPEED_GAIN_RST     = 15'd256;
	localparam logic [14:0] MIN_BRAKE_SPEED_RST      = 15'd0;

	// Default tuning constants of the top level.
	localparam logic [14:0] SLOWDOWN_GAIN_DEF   = 15'd256;
	localparam logic [8:0]  MAX_SLOWDOWN_DEF    = 9'd128;
	localparam logic [14:0] ROLLER_DISTANCE_DEF = 15'd64;

	// Q1.8 one, the unscaled speed factor.
	localparam logic [8:0] Q88_ONE = 9'd256;

	// Multiplier operand and product widths.
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Controller to datapath command bundle.
	typedef struct packed {
		logic [2:0] op;
		logic       load_in;
		logic       decide;
		logic       load_out;
		logic [2:0] kind;
	} bcsc_cmd_t;

	// Datapath to controller status bundle.
	typedef struct packed {
		logic busy;
		logic ball;
		logic seen;
		logic new_target;
	} bcsc_status_t;

endpackage

/* src/bcsc_regs.sv */
// Configuration register file of the ball chase speed controller.
// Depends on bcsc_pkg for the register struct, indexes and reset values.
module bcsc_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output bcsc_pkg::bcsc_cfg_t  cfg
);
	import bcsc_pkg::*;

	bcsc_cfg_t cfg_q;

	// Writes are always taken; software must write only while the block is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus_gain          <= FOCUS_GAIN_RST;
			cfg_q.max_turn_rate       <= MAX_TURN_RATE_RST;
			cfg_q.far_speed           <= FAR_SPEED_RST;
			cfg_q.near_speed          <= NEAR_SPEED_RST;
			cfg_q.close_distance      <= CLOSE_DISTANCE_RST;
			cfg_q.brake_distance_gain <= BRAKE_DISTANCE_GAIN_RST;
			cfg_q.brake_speed_gain    <= BRAKE_SPEED_GAIN_RST;
			cfg_q.min_brake_speed     <= MIN_BRAKE_SPEED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOCUS_GAIN:          cfg_q.focus_gain          <= $signed(cfg_data);
				REG_MAX_TURN_RATE:       cfg_q.max_turn_rate       <= cfg_data[14:0];
				REG_FAR_SPEED:           cfg_q.far_speed           <= cfg_data[14:0];
				REG_NEAR_SPEED:          cfg_q.near_speed          <= cfg_data[14:0];
				REG_CLOSE_DISTANCE:      cfg_q.close_distance      <= cfg_data[14:0];
				REG_BRAKE_DISTANCE_GAIN: cfg_q.brake_distance_gain <= cfg_data[14:0];
				REG_BRAKE_SPEED_GAIN:    cfg_q.brake_speed_gain    <= cfg_data[14:0];
				REG_MIN_BRAKE_SPEED:     cfg_q.min_brake_speed     <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* src/bcsc_datapath.sv */
// Datapath of the ball chase speed controller: input register, one shared
// multiplier with its product register, intermediate results, tracking flags
// and the result register. Depends on bcsc_pkg.
module bcsc_datapath #(
	parameter logic [14:0] SLOWDOWN_GAIN   = bcsc_pkg::SLOWDOWN_GAIN_DEF,
	parameter logic [8:0]  MAX_SLOWDOWN    = bcsc_pkg::MAX_SLOWDOWN_DEF,
	parameter logic [14:0] ROLLER_DISTANCE = bcsc_pkg::ROLLER_DISTANCE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bcsc_pkg::bcsc_cfg_t    cfg,
	input  bcsc_pkg::bcsc_cmd_t    cmd,
	output bcsc_pkg::bcsc_status_t status,
	input  bcsc_pkg::bcsc_in_t     item,
	output bcsc_pkg::bcsc_out_t    result
);
	import bcsc_pkg::*;

	// Saturate a 24-bit signed value to the 16-bit field range.
	function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
		logic signed [15:0] r;
		if (x > 24'sd32767) begin
			r = 16'sd32767;
		end else if (x < -24'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	bcsc_in_t                  in_q;
	bcsc_out_t                 result_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [2:0]                prod_op_q;
	logic signed [15:0]        omega_q;
	logic signed [30:0]        brake_q;
	logic [21:0]               bspd_q;
	logic [8:0]                slowc_q;
	logic signed [23:0]        speed_q;
	logic                      new_target_q;
	logic                      search_neg_q;
	logic                      near_reached_q;
	logic signed [15:0]        prev_vel_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [16:0]               abs_angle;
	logic signed [23:0]        omega_raw;
	logic signed [23:0]        max_turn_s;
	logic signed [15:0]        omega_clamp;
	logic signed [30:0]        brake_raw;
	logic signed [22:0]        bspd_raw;
	logic [21:0]               slow_raw;
	logic [8:0]                slow_lim;
	logic signed [16:0]        search_raw;
	logic signed [15:0]        search_turn;
	logic                      inside_brake;
	logic                      braking;
	bcsc_out_t                 result_n;

	assign status.busy       = in_q.busy_req;
	assign status.ball       = in_q.holding_ball;
	assign status.seen       = in_q.target_seen;
	assign status.new_target = new_target_q;
	assign result            = result_q;

	// Absolute target angle, one bit wider so the most negative angle fits.
	assign abs_angle = in_q.target_angle[15] ? (17'd0 - {1'b1, in_q.target_angle})
		: {1'b0, in_q.target_angle};

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_OMEGA: begin
				mul_a = MUL_A_W'(in_q.target_angle);
				mul_b = cfg.focus_gain;
			end
			OP_T1: begin
				mul_a = $signed({9'd0, cfg.close_distance});
				mul_b = in_q.forward_velocity;
			end
			OP_BRAKE: begin
				// Scaled close distance straight from the previous product.
				mul_a = MUL_A_W'($signed(prod_q[30:8]));
				mul_b = $signed({1'b0, cfg.brake_distance_gain});
			end
			OP_BSPD: begin
				mul_a = $signed({9'd0, cfg.brake_speed_gain});
				mul_b = in_q.forward_velocity;
			end
			OP_SLOW: begin
				mul_a = $signed({7'd0, abs_angle});
				mul_b = $signed({1'b0, SLOWDOWN_GAIN});
			end
			OP_SPEED: begin
				mul_a = speed_q;
				mul_b = $signed({7'd0, slowc_q});
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier with its product register and operation tag.
	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			prod_q <= mul_a * mul_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_op_q <= OP_NONE;
		end else if (cmd.op != OP_NONE) begin
			prod_op_q <= cmd.op;
		end
	end

	// Post-processing of each product: shift, clamp and limit.
	assign omega_raw  = prod_q[31:8];
	assign max_turn_s = $signed({9'd0, cfg.max_turn_rate});
	always_comb begin
		if (omega_raw > max_turn_s) begin
			omega_clamp = $signed({1'b0, cfg.max_turn_rate});
		end else if (omega_raw < -max_turn_s) begin
			omega_clamp = -$signed({1'b0, cfg.max_turn_rate});
		end else begin
			omega_clamp = omega_raw[15:0];
		end
	end

	assign brake_raw = prod_q[38:8];
	assign bspd_raw  = prod_q[30:8];
	assign slow_raw  = prod_q[29:8];
	assign slow_lim  = (slow_raw > {13'd0, MAX_SLOWDOWN}) ? MAX_SLOWDOWN : slow_raw[8:0];

	// Capture the intermediate that the tagged product belongs to.
	always_ff @(posedge clk) begin
		case (prod_op_q)
			OP_OMEGA: omega_q <= omega_clamp;
			OP_BRAKE: begin
				if (brake_raw < $signed({16'd0, cfg.close_distance})) begin
					brake_q <= $signed({16'd0, cfg.close_distance});
				end else begin
					brake_q <= brake_raw;
				end
			end
			OP_BSPD: begin
				if (bspd_raw < $signed({8'd0, cfg.min_brake_speed})) begin
					bspd_q <= {7'd0, cfg.min_brake_speed};
				end else begin
					bspd_q <= bspd_raw[21:0];
				end
			end
			OP_SLOW: slowc_q <= Q88_ONE - slow_lim;
			default: begin
			end
		endcase
	end

	// Speed choice against the brake distance, with reverse braking while slowing.
	assign inside_brake = !($signed({16'd0, in_q.target_distance}) > brake_q);
	assign braking = (in_q.forward_velocity > $signed({1'b0, cfg.near_speed}))
		&& (in_q.forward_velocity < prev_vel_q);

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (!inside_brake) begin
				speed_q <= $signed({9'd0, cfg.far_speed});
			end else if (!near_reached_q && braking) begin
				speed_q <= -$signed({2'd0, bspd_q});
			end else begin
				speed_q <= $signed({9'd0, cfg.near_speed});
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= item;
		end
	end

	// Tracking flags and the previous velocity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_target_q   <= 1'b1;
			search_neg_q   <= 1'b0;
			near_reached_q <= 1'b0;
			prev_vel_q     <= '0;
		end else begin
			if (cmd.decide) begin
				prev_vel_q <= in_q.forward_velocity;
				if (inside_brake && !near_reached_q && !braking) begin
					near_reached_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				case (cmd.kind)
					KIND_SEARCH: new_target_q <= 1'b1;
					KIND_STOP: begin
						new_target_q   <= 1'b0;
						near_reached_q <= 1'b0;
						search_neg_q   <= !search_neg_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Search turn rate; negating the most negative gain saturates.
	assign search_raw = search_neg_q ? -17'(cfg.focus_gain) : 17'(cfg.focus_gain);
	assign search_turn = sat16(24'(search_raw));

	// Result assembly by command kind.
	always_comb begin
		result_n = '0;
		result_n.command_kind = cmd.kind;
		case (cmd.kind)
			KIND_ROLLER: result_n.roller_command = ROLLER_START;
			KIND_SEARCH: result_n.turn_rate = search_turn;
			KIND_DRIVE: begin
				result_n.forward_speed  = sat16(prod_q[31:8]);
				result_n.turn_rate      = omega_q;
				result_n.roller_command = (in_q.target_distance <= ROLLER_DISTANCE)
					? ROLLER_START : ROLLER_STOP;
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q <= result_n;
		end
	end

endmodule

/* src/bcsc_ctrl.sv */
// Controller state machine of the ball chase speed controller: item and result
// handshakes, command kind selection and the multiply sequence. Depends on bcsc_pkg.
module bcsc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  bcsc_pkg::bcsc_status_t status,
	output bcsc_pkg::bcsc_cmd_t    cmd
);
	import bcsc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_T1       = 4'd2;
	localparam logic [3:0] S_BRAKE    = 4'd3;
	localparam logic [3:0] S_BSPD     = 4'd4;
	localparam logic [3:0] S_SLOW     = 4'd5;
	localparam logic [3:0] S_DECIDE   = 4'd6;
	localparam logic [3:0] S_SPEED    = 4'd7;
	localparam logic [3:0] S_EMIT     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic [2:0] kind_q;
	logic [2:0] kind_n;
	logic       result_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	// Next state, command kind and datapath commands.
	always_comb begin
		state_n     = state_q;
		kind_n      = kind_q;
		cmd         = '0;
		cmd.kind    = kind_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				// The turn-rate product starts at once; it is only used when driving.
				cmd.op  = OP_OMEGA;
				state_n = S_EMIT;
				if (status.busy) begin
					kind_n = KIND_NONE;
				end else if (status.ball) begin
					kind_n = KIND_ROLLER;
				end else if (!status.seen) begin
					kind_n = KIND_SEARCH;
				end else if (status.new_target) begin
					kind_n = KIND_STOP;
				end else begin
					kind_n  = KIND_DRIVE;
					state_n = S_T1;
				end
			end
			S_T1: begin
				cmd.op  = OP_T1;
				state_n = S_BRAKE;
			end
			S_BRAKE: begin
				cmd.op  = OP_BRAKE;
				state_n = S_BSPD;
			end
			S_BSPD: begin
				cmd.op  = OP_BSPD;
				state_n = S_SLOW;
			end
			S_SLOW: begin
				cmd.op  = OP_SLOW;
				state_n = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_n    = S_SPEED;
			end
			S_SPEED: begin
				cmd.op  = OP_SPEED;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				// Wait for the result register to be free.
				if (!result_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// State, kind and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			kind_q         <= KIND_NONE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			kind_q  <= kind_n;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/ball_chase_speed_controller_unit.sv */
// Top level of the ball chase speed controller: configuration registers,
// controller and datapath. Depends on bcsc_pkg, bcsc_regs, bcsc_ctrl, bcsc_datapath.
//
// One item is in work at a time. A busy, ball-held, search or stop item goes from
// acceptance through the dispatch state to the emit state; a drive item passes
// through the states of six products that share one 24x16 multiplier and of the
// speed decision before the emit state. The block takes the next item in the
// cycle after the result is loaded into the output register, so a waiting result
// only holds the block when a further result is ready to be loaded. Configuration
// writes are taken in every cycle and are meant to happen while no item is in work.
module ball_chase_speed_controller_unit #(
	parameter logic [14:0] SLOWDOWN_GAIN   = bcsc_pkg::SLOWDOWN_GAIN_DEF,
	parameter logic [8:0]  MAX_SLOWDOWN    = bcsc_pkg::MAX_SLOWDOWN_DEF,
	parameter logic [14:0] ROLLER_DISTANCE = bcsc_pkg::ROLLER_DISTANCE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  bcsc_pkg::bcsc_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output bcsc_pkg::bcsc_out_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import bcsc_pkg::*;

	bcsc_cfg_t    cfg;
	bcsc_cmd_t    cmd;
	bcsc_status_t status;

	// Configuration registers.
	bcsc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencing and handshakes.
	bcsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Arithmetic and state.
	bcsc_datapath #(
		.SLOWDOWN_GAIN   (SLOWDOWN_GAIN),
		.MAX_SLOWDOWN    (MAX_SLOWDOWN),
		.ROLLER_DISTANCE (ROLLER_DISTANCE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result)
	);

endmodule

/* test/tb_ball_chase_speed_controller_unit.sv */
// Self-checking testbench for ball_chase_speed_controller_unit.
// Predicts every command from the control ticks and register writes it sends.
// Depends on bcsc_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb_ball_chase_speed_controller_unit;
	import bcsc_pkg::*;

	// Drive item sequence length, receiver hold and watchdog limits.
	localparam int DRIVE_CYCLES = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;

	typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_SPARSE} rx_pattern_e;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	bcsc_in_t    tick_bus     = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	bcsc_out_t   cmd_bus;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index    = '0;
	logic [15:0] cfg_data     = '0;

	// Predictor copy of the registers and of the chase state.
	bcsc_cfg_t tuning = '{
		focus_gain:          FOCUS_GAIN_RST,
		max_turn_rate:       MAX_TURN_RATE_RST,
		far_speed:           FAR_SPEED_RST,
		near_speed:          NEAR_SPEED_RST,
		close_distance:      CLOSE_DISTANCE_RST,
		brake_distance_gain: BRAKE_DISTANCE_GAIN_RST,
		brake_speed_gain:    BRAKE_SPEED_GAIN_RST,
		min_brake_speed:     MIN_BRAKE_SPEED_RST
	};
	logic               fresh_target  = 1'b1;
	logic               search_ccw    = 1'b0;
	logic               approach_done = 1'b0;
	logic signed [15:0] last_velocity = '0;

	bcsc_out_t pending_cmds[$];
	int        mismatches    = 0;
	int        results_seen  = 0;
	int        ticks_sent    = 0;
	int        burst_left    = 0;
	bit        steady_sender = 1'b0;
	bit        hold_request  = 1'b0;

	ball_chase_speed_controller_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (tick_bus),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (cmd_bus),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Saturate a wide intermediate to a signed 16-bit field.
	function automatic logic signed [15:0] clip16(input longint x);
		if (x > 32767) begin
			return 16'sh7FFF;
		end
		if (x < -32768) begin
			return 16'sh8000;
		end
		return 16'(x);
	endfunction

	// Work out the command for one tick and advance the predicted chase state.
	function automatic bcsc_out_t predict_command(input bcsc_in_t t);
		bcsc_out_t c;
		longint angle, tgt_dist, vel, focus, clamp, turn, brake_dist, speed, brake_speed, slowdown;
		c = '0;
		angle = longint'($signed(t.target_angle));
		tgt_dist = longint'(t.target_distance);
		vel = longint'($signed(t.forward_velocity));
		focus = longint'($signed(tuning.focus_gain));
		if (t.busy_req) begin
			c.command_kind = KIND_NONE;
		end else if (t.holding_ball) begin
			c.command_kind = KIND_ROLLER;
			c.roller_command = ROLLER_START;
		end else if (!t.target_seen) begin
			// Lost target: spin in the current search direction.
			c.command_kind = KIND_SEARCH;
			c.turn_rate = clip16(search_ccw ? -focus : focus);
			fresh_target = 1'b1;
		end else if (fresh_target) begin
			// First sighting: stop turning and flip the next search direction.
			c.command_kind = KIND_STOP;
			fresh_target = 1'b0;
			approach_done = 1'b0;
			search_ccw = ~search_ccw;
		end else begin
			clamp = longint'(tuning.max_turn_rate);
			turn = (angle * focus) >>> 8;
			if (turn > clamp) begin
				turn = clamp;
			end
			if (turn < -clamp) begin
				turn = -clamp;
			end
			brake_dist = (((longint'(tuning.close_distance) * vel) >>> 8)
				* longint'(tuning.brake_distance_gain)) >>> 8;
			if (brake_dist < longint'(tuning.close_distance)) begin
				brake_dist = longint'(tuning.close_distance);
			end
			if (tgt_dist > brake_dist) begin
				speed = longint'(tuning.far_speed);
			end else begin
				speed = longint'(tuning.near_speed);
				// Reverse brake while still approaching faster than near speed and slowing.
				if (!approach_done) begin
					if (vel > longint'(tuning.near_speed) && vel < longint'(last_velocity)) begin
						brake_speed = (longint'(tuning.brake_speed_gain) * vel) >>> 8;
						if (brake_speed < longint'(tuning.min_brake_speed)) begin
							brake_speed = longint'(tuning.min_brake_speed);
						end
						speed = -brake_speed;
					end else begin
						approach_done = 1'b1;
					end
				end
			end
			slowdown = ((angle < 0 ? -angle : angle) * longint'(SLOWDOWN_GAIN_DEF)) >>> 8;
			if (slowdown > longint'(MAX_SLOWDOWN_DEF)) begin
				slowdown = longint'(MAX_SLOWDOWN_DEF);
			end
			if (slowdown < 0) begin
				slowdown = 0;
			end
			speed = (speed * (longint'(Q88_ONE) - slowdown)) >>> 8;
			c.command_kind = KIND_DRIVE;
			c.forward_speed = clip16(speed);
			c.turn_rate = clip16(turn);
			c.roller_command = (tgt_dist <= longint'(ROLLER_DISTANCE_DEF))
				? ROLLER_START : ROLLER_STOP;
			last_velocity = t.forward_velocity;
		end
		return c;
	endfunction

	function automatic bcsc_in_t make_tick(input bit busy, input bit ball, input bit seen,
		input int angle, input int dist_in, input int vel);
		bcsc_in_t t;
		t.busy_req = busy;
		t.holding_ball = ball;
		t.target_seen = seen;
		t.target_angle = 16'(angle);
		t.target_distance = 15'(dist_in);
		t.forward_velocity = 16'(vel);
		return t;
	endfunction

	function automatic bcsc_in_t random_item();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(bcsc_in_t)-1:0];
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		// Keep the log readable when the block is badly broken.
		if (mismatches <= 100) begin
			$display("ERROR: %s", msg);
		end
	endtask

	// Offer one tick in bursts with random gaps, then record its predicted command.
	task automatic send_tick(input bcsc_in_t t);
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady_sender && $urandom_range(0, 3) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		tick_bus <= t;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		burst_left--;
		ticks_sent++;
		pending_cmds.push_back(predict_command(t));
	endtask

	// Register write; the predictor takes the new value when the write is accepted.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_FOCUS_GAIN:          tuning.focus_gain = data;
			REG_MAX_TURN_RATE:       tuning.max_turn_rate = data[14:0];
			REG_FAR_SPEED:           tuning.far_speed = data[14:0];
			REG_NEAR_SPEED:          tuning.near_speed = data[14:0];
			REG_CLOSE_DISTANCE:      tuning.close_distance = data[14:0];
			REG_BRAKE_DISTANCE_GAIN: tuning.brake_distance_gain = data[14:0];
			REG_BRAKE_SPEED_GAIN:    tuning.brake_speed_gain = data[14:0];
			REG_MIN_BRAKE_SPEED:     tuning.min_brake_speed = data[14:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [15:0] focus, input logic [15:0] rest);
		int r;
		for (r = REG_FOCUS_GAIN; r <= REG_MIN_BRAKE_SPEED; r++) begin
			write_reg(3'(r), (3'(r) == REG_FOCUS_GAIN) ? focus : rest);
		end
	endtask

	// Mostly tuning values that keep braking reachable, sometimes the full field.
	task automatic load_random_tuning();
		int r;
		logic [15:0] val;
		for (r = REG_FOCUS_GAIN; r <= REG_MIN_BRAKE_SPEED; r++) begin
			val = 16'($urandom());
			if ($urandom_range(0, 3) != 0) begin
				case (3'(r))
					REG_FOCUS_GAIN:    val = 16'(int'($urandom_range(0, 4096)) - 2048);
					REG_MAX_TURN_RATE: val = 16'($urandom_range(0, 4096));
					REG_FAR_SPEED, REG_NEAR_SPEED, REG_CLOSE_DISTANCE: begin
						val = 16'($urandom_range(0, 2048));
					end
					default:           val = 16'($urandom_range(0, 1024));
				endcase
			end
			write_reg(3'(r), val);
		end
	endtask

	// Drop valid, let every outstanding command drain and the datapath go quiet.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_cmds.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRIVE_CYCLES + 3) @(posedge clk);
		burst_left = 0;
	endtask

	// One chase: a few search ticks, then closing in with a mostly falling velocity.
	task automatic run_chase();
		bcsc_in_t t;
		int searches, steps, i;
		longint vel, tgt_dist;
		searches = $urandom_range(1, 3);
		for (i = 0; i < searches; i++) begin
			t = random_item();
			t.busy_req = 1'b0;
			t.holding_ball = 1'b0;
			t.target_seen = 1'b0;
			send_tick(t);
		end
		vel = longint'(tuning.near_speed) + longint'($urandom_range(0, 3000)) - 200;
		tgt_dist = longint'($urandom_range(0, 6000));
		steps = $urandom_range(2, 14);
		for (i = 0; i < steps; i++) begin
			if (vel > 32767) begin
				vel = 32767;
			end
			if (vel < -32768) begin
				vel = -32768;
			end
			t = random_item();
			t.busy_req = ($urandom_range(0, 15) == 0);
			t.holding_ball = ($urandom_range(0, 19) == 0);
			t.target_seen = ($urandom_range(0, 24) != 0);
			if ($urandom_range(0, 7) != 0) begin
				t.target_angle = 16'(int'($urandom_range(0, 1200)) - 600);
			end
			t.target_distance = 15'(tgt_dist);
			t.forward_velocity = 16'(vel);
			send_tick(t);
			tgt_dist = tgt_dist - longint'($urandom_range(0, 800));
			if (tgt_dist < 0) begin
				tgt_dist = 0;
			end
			if ($urandom_range(0, 9) == 0) begin
				vel = vel + longint'($urandom_range(0, 300));
			end else begin
				vel = vel - longint'($urandom_range(0, 400));
			end
		end
	endtask

	// Every command kind, angle and distance extremes, and the reverse-brake sequence.
	task automatic test_directed_defaults();
		send_tick(make_tick(1, 1, 1, 32767, 32767, 32767));
		send_tick(make_tick(0, 1, 0, -32768, 0, -32768));
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, 1, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 100, 100, 100));
		send_tick(make_tick(0, 0, 1, 0, 0, 0));
		send_tick(make_tick(0, 0, 1, 0, 32767, 2000));
		send_tick(make_tick(0, 0, 1, 0, 100, 1500));
		send_tick(make_tick(0, 0, 1, 0, 64, 1400));
		send_tick(make_tick(0, 0, 1, 0, 65, 1450));
		send_tick(make_tick(0, 0, 1, 32767, 0, 1000));
		send_tick(make_tick(0, 0, 1, -32768, 0, 1000));
		send_tick(make_tick(0, 0, 1, -1, 300, 0));
		send_tick(make_tick(0, 0, 1, 1, 32767, -32768));
		send_tick(make_tick(0, 0, 1, 128, 0, 32767));
		send_tick(make_tick(1, 0, 0, -5, 5, -5));
		send_tick(make_tick(0, 1, 1, 0, 0, 0));
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, 1, 0, 0, 0));
	endtask

	// Register extremes; unsigned registers also see bit 15 set, which they drop.
	task automatic test_register_extremes();
		int s, i;
		for (s = 0; s < 4; s++) begin
			settle();
			case (s)
				0:       write_all_regs(16'h7FFF, 16'hFFFF);
				1:       write_all_regs(16'h8000, 16'h0000);
				2:       write_all_regs(16'h8000, 16'h7FFF);
				default: write_all_regs(16'hFFFF, 16'h8001);
			endcase
			for (i = 0; i < 3; i++) begin
				run_chase();
			end
			for (i = 0; i < 6; i++) begin
				send_tick(random_item());
			end
		end
	endtask

	task automatic test_random_chase();
		int phase, goal;
		for (phase = 0; phase < 6; phase++) begin
			settle();
			load_random_tuning();
			goal = ticks_sent + 250;
			while (ticks_sent < goal) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 5)) send_tick(random_item());
				end else begin
					run_chase();
				end
			end
		end
	endtask

	// The receiver holds off while ticks keep coming, so the block backs up to its input.
	task automatic test_output_backpressure();
		int i;
		settle();
		steady_sender = 1'b1;
		hold_request = 1'b1;
		for (i = 0; i < 4; i++) begin
			run_chase();
		end
		steady_sender = 1'b0;
	endtask

	// Receiver stall patterns, plus one long hold when asked for.
	initial begin : result_sink
		rx_pattern_e pattern;
		int span, tick_no;
		pattern = RX_OPEN;
		span = 0;
		tick_no = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (span == 0) begin
				pattern = rx_pattern_e'($urandom_range(0, 3));
				span = $urandom_range(30, 300);
			end
			span--;
			tick_no++;
			case (pattern)
				RX_OPEN:       result_ready <= 1'b1;
				RX_COIN:       result_ready <= 1'($urandom_range(0, 1));
				RX_RARE_STALL: result_ready <= ($urandom_range(0, 7) != 0);
				default:       result_ready <= (tick_no % 4 == 0);
			endcase
		end
	end

	// Compare each accepted command with the oldest prediction.
	always @(posedge clk) begin : result_check
		bcsc_out_t want;
		if (result_valid && result_ready) begin
			if (pending_cmds.size() == 0) begin
				report_error($sformatf("command %0d arrived with nothing outstanding", results_seen));
			end else begin
				want = pending_cmds.pop_front();
				if (cmd_bus.command_kind !== want.command_kind) begin
					report_error($sformatf("command %0d kind: got %0d, want %0d", results_seen,
						cmd_bus.command_kind, want.command_kind));
				end
				if (cmd_bus.forward_speed !== want.forward_speed) begin
					report_error($sformatf("command %0d forward_speed: got %0d, want %0d",
						results_seen, $signed(cmd_bus.forward_speed), $signed(want.forward_speed)));
				end
				if (cmd_bus.turn_rate !== want.turn_rate) begin
					report_error($sformatf("command %0d turn_rate: got %0d, want %0d",
						results_seen, $signed(cmd_bus.turn_rate), $signed(want.turn_rate)));
				end
				if (cmd_bus.roller_command !== want.roller_command) begin
					report_error($sformatf("command %0d roller: got %0d, want %0d", results_seen,
						cmd_bus.roller_command, want.roller_command));
				end
			end
			results_seen++;
		end
	end

	// Ends the run when no channel moves an item for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TIMEOUT: no handshake for %0d cycles, %0d commands outstanding",
			STALL_LIMIT, pending_cmds.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_register_extremes();
		test_random_chase();
		test_output_backpressure();
		settle();
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
